// ===== rtl/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// pee_pkg
// Shared types and constants of the postfix expression evaluator.
// ----------------------------------------------------------------------------
package pee_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIX,
        A_DONE
    } t_alu_state;

    typedef enum logic [2:0] {
        CTL_IDLE,
        CTL_DECODE,
        CTL_RD_RHS,
        CTL_RD_LHS,
        CTL_EXEC,
        CTL_FINISH,
        CTL_EMIT
    } t_ctl_state;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
        logic div_zero;
    } t_alu_rsp;

endpackage

// ===== rtl/pee_ram.sv =====
// ----------------------------------------------------------------------------
// pee_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/pee_alu.sv =====
// ----------------------------------------------------------------------------
// pee_alu
// Saturating Q16.16 arithmetic unit built round one 33-bit adder: add and
// subtract in one pass, multiply and divide one bit per cycle.
// ----------------------------------------------------------------------------
module pee_alu import pee_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_req          i_req,
    input  logic [DATA_W-1:0] i_lhs,
    input  logic [DATA_W-1:0] i_rhs,
    output t_alu_rsp          o_rsp,
    output logic [DATA_W-1:0] o_result
);

    t_alu_state  r_state, n_state;
    t_alu_op     r_op, n_op;
    logic        r_neg, n_neg;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_mag, n_mag;
    logic [31:0] r_result, n_result;
    logic        r_divz, n_divz;

    logic [31:0] abs_l;
    logic [31:0] abs_r;
    logic        sign_diff;
    logic [32:0] add_a;
    logic [32:0] add_b;
    logic        add_cin;
    logic [32:0] add_sum;
    logic [31:0] addsub_res;
    logic [31:0] div_shift;
    logic [47:0] mul_hi;
    logic [48:0] mul_ceil;
    logic [31:0] fix_res;

    assign abs_l     = i_lhs[31] ? (~i_lhs + 32'd1) : i_lhs;
    assign abs_r     = i_rhs[31] ? (~i_rhs + 32'd1) : i_rhs;
    assign sign_diff = i_lhs[31] ^ i_rhs[31];
    assign div_shift = {r_rem[30:0], r_acc[31]};

    always_comb begin
        add_a   = {i_lhs[31], i_lhs};
        add_b   = {i_rhs[31], i_rhs};
        add_cin = 1'b0;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.op == ALU_SUB) begin
                    add_b   = ~{i_rhs[31], i_rhs};
                    add_cin = 1'b1;
                end
            end
            A_MUL: begin
                add_a = {1'b0, r_acc[63:32]};
                add_b = r_acc[0] ? {1'b0, r_mag} : 33'd0;
            end
            A_DIV: begin
                add_a   = {1'b0, div_shift};
                add_b   = ~{1'b0, r_mag};
                add_cin = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign add_sum    = add_a + add_b + {32'd0, add_cin};
    assign addsub_res = (add_sum[32] != add_sum[31]) ? (add_sum[32] ? Q_MIN : Q_MAX)
                                                     : add_sum[31:0];

    assign mul_hi   = r_acc[63:16];
    assign mul_ceil = {1'b0, mul_hi} + {48'd0, (r_acc[15:0] != 16'd0)};

    always_comb begin
        if (r_op == ALU_MUL) begin
            if (!r_neg) begin
                fix_res = (mul_hi > 48'h0000_7FFF_FFFF) ? Q_MAX : mul_hi[31:0];
            end else begin
                fix_res = (mul_ceil > 49'h0_0000_8000_0000) ? Q_MIN
                                                             : (~mul_ceil[31:0] + 32'd1);
            end
        end else begin
            if (!r_neg) begin
                fix_res = r_acc[31] ? Q_MAX : r_acc[31:0];
            end else begin
                fix_res = (r_acc[31:0] > 32'h8000_0000) ? Q_MIN : (~r_acc[31:0] + 32'd1);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_neg    = r_neg;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_mag    = r_mag;
        n_result = r_result;
        n_divz   = r_divz;
        unique case (r_state)
            A_IDLE: begin
                if (i_req.start) begin
                    n_op   = i_req.op;
                    n_neg  = sign_diff;
                    n_cnt  = 5'd0;
                    n_divz = 1'b0;
                    unique case (i_req.op)
                        ALU_ADD, ALU_SUB: begin
                            n_result = addsub_res;
                            n_state  = A_DONE;
                        end
                        ALU_MUL: begin
                            n_acc   = {32'd0, abs_r};
                            n_mag   = abs_l;
                            n_state = A_MUL;
                        end
                        ALU_DIV: begin
                            if (i_rhs == 32'd0) begin
                                n_result = 32'd0;
                                n_divz   = 1'b1;
                                n_state  = A_DONE;
                            end else if ({16'd0, abs_l[31:16]} >= abs_r) begin
                                n_result = sign_diff ? Q_MIN : Q_MAX;
                                n_state  = A_DONE;
                            end else begin
                                n_rem   = {16'd0, abs_l[31:16]};
                                n_acc   = {32'd0, abs_l[15:0], 16'd0};
                                n_mag   = abs_r;
                                n_state = A_DIV;
                            end
                        end
                    endcase
                end
            end
            A_MUL: begin
                n_acc = {add_sum, r_acc[31:1]};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = A_FIX;
                end
            end
            A_DIV: begin
                n_rem = add_sum[32] ? div_shift : add_sum[31:0];
                n_acc = {32'd0, r_acc[30:0], ~add_sum[32]};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = A_FIX;
                end
            end
            A_FIX: begin
                n_result = fix_res;
                n_state  = A_DONE;
            end
            A_DONE: begin
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_neg    <= n_neg;
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_rem    <= n_rem;
        r_mag    <= n_mag;
        r_result <= n_result;
        r_divz   <= n_divz;
    end

    assign o_rsp.done     = (r_state == A_DONE);
    assign o_rsp.div_zero = r_divz;
    assign o_result       = r_result;

endmodule

// ===== rtl/postfix_expression_evaluator.sv =====
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// Evaluates a postfix expression one character per transaction on a Q16.16
// value stack, with a sticky error status and one result per expression.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------
//  in      | input     | i_in_valid / o_in_ready  | i_symbol, i_last
//  out     | output    | o_out_valid / i_out_ready| o_value, o_status
//
//  Multiply and divide run the shared 33-bit adder one bit per cycle over 32
//  steps, then a fix-up and a done step; a zero divisor or an early
//  saturating quotient skips the bit steps and the fix-up. A transaction
//  marked last also waits in CTL_EMIT until the output register is free.
//  Reset is synchronous, active low; no stack clearing pass is needed.
//  o_in_ready is low while a transaction is processed; the result register
//  frees the core unless a second result waits on a stalled output.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator import pee_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_symbol,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [DATA_W-1:0] o_value,
    output logic [1:0]        o_status
);

    t_ctl_state        r_state, n_state;
    logic [SP_W-1:0]   r_sp, n_sp;
    t_status           r_err, n_err;
    logic              r_out_valid, n_out_valid;
    logic              r_top_ok, n_top_ok;
    logic [7:0]        r_symbol, n_symbol;
    logic              r_last, n_last;
    t_alu_op           r_op, n_op;
    logic [DATA_W-1:0] r_rhs, n_rhs;
    logic [DATA_W-1:0] r_value, n_value;
    t_status           r_status, n_status;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [DATA_W-1:0] ram_rd_data;

    t_alu_req          alu_req;
    t_alu_rsp          alu_rsp;
    logic [DATA_W-1:0] alu_result;

    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    logic [3:0]        digit;
    logic              is_digit;
    logic              is_op;
    logic              out_free;

    assign sp_m1    = r_sp - SP_W'(1);
    assign sp_m2    = r_sp - SP_W'(2);
    assign digit    = 4'(r_symbol - CH_ZERO);
    assign is_digit = (r_symbol >= CH_ZERO) && (r_symbol <= CH_NINE);
    assign is_op    = (r_symbol == CH_PLUS) || (r_symbol == CH_MINUS) ||
                      (r_symbol == CH_STAR) || (r_symbol == CH_SLASH);
    assign out_free = !r_out_valid || i_out_ready;

    pee_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    pee_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_lhs    (ram_rd_data),
        .i_rhs    (r_rhs),
        .o_rsp    (alu_rsp),
        .o_result (alu_result)
    );

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        n_err       = r_err;
        n_out_valid = r_out_valid && !i_out_ready;
        n_top_ok    = r_top_ok;
        n_symbol    = r_symbol;
        n_last      = r_last;
        n_op        = r_op;
        n_rhs       = r_rhs;
        n_value     = r_value;
        n_status    = r_status;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_sp[ADDR_W-1:0];
        ram_wr_data = {12'd0, digit, 16'd0};
        ram_rd_en   = 1'b0;
        ram_rd_addr = sp_m1[ADDR_W-1:0];
        alu_req     = '{start: 1'b0, op: r_op};
        o_in_ready  = 1'b0;
        unique case (r_state)
            CTL_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_symbol = i_symbol;
                    n_last   = i_last;
                    n_state  = CTL_DECODE;
                end
            end
            CTL_DECODE: begin
                n_state = CTL_FINISH;
                unique case (r_symbol)
                    CH_PLUS:  n_op = ALU_ADD;
                    CH_MINUS: n_op = ALU_SUB;
                    CH_STAR:  n_op = ALU_MUL;
                    default:  n_op = ALU_DIV;
                endcase
                if (is_digit) begin
                    if (r_sp < SP_W'(STACK_DEPTH)) begin
                        ram_wr_en = 1'b1;
                        n_sp      = r_sp + SP_W'(1);
                    end else if (r_err == ST_OK) begin
                        n_err = ST_OVER;
                    end
                end else if (is_op) begin
                    if (r_sp < SP_W'(2)) begin
                        if (r_err == ST_OK) begin
                            n_err = ST_UNDER;
                        end
                    end else begin
                        ram_rd_en = 1'b1;
                        n_state   = CTL_RD_RHS;
                    end
                end
            end
            CTL_RD_RHS: begin
                n_rhs       = ram_rd_data;
                ram_rd_en   = 1'b1;
                ram_rd_addr = sp_m2[ADDR_W-1:0];
                n_state     = CTL_RD_LHS;
            end
            CTL_RD_LHS: begin
                alu_req = '{start: 1'b1, op: r_op};
                n_sp    = sp_m2;
                n_state = CTL_EXEC;
            end
            CTL_EXEC: begin
                if (alu_rsp.done) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = alu_result;
                    n_sp        = r_sp + SP_W'(1);
                    if (alu_rsp.div_zero && (r_err == ST_OK)) begin
                        n_err = ST_DIVZ;
                    end
                    n_state = CTL_FINISH;
                end
            end
            CTL_FINISH: begin
                if (!r_last) begin
                    n_state = CTL_IDLE;
                end else begin
                    if (r_sp != SP_W'(0)) begin
                        ram_rd_en = 1'b1;
                        n_top_ok  = 1'b1;
                    end else begin
                        n_top_ok = 1'b0;
                        if (r_err == ST_OK) begin
                            n_err = ST_UNDER;
                        end
                    end
                    n_state = CTL_EMIT;
                end
            end
            CTL_EMIT: begin
                if (out_free) begin
                    n_value     = r_top_ok ? ram_rd_data : {DATA_W{1'b0}};
                    n_status    = r_err;
                    n_out_valid = 1'b1;
                    n_sp        = SP_W'(0);
                    n_err       = ST_OK;
                    n_state     = CTL_IDLE;
                end
            end
            default: begin
                n_state = CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= CTL_IDLE;
            r_sp        <= SP_W'(0);
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
            r_top_ok    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            r_top_ok    <= n_top_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_symbol <= n_symbol;
        r_last   <= n_last;
        r_op     <= n_op;
        r_rhs    <= n_rhs;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;

endmodule

// ===== sim/pee_checker.sv =====
// ----------------------------------------------------------------------------
// pee_checker
// Watches both channels of the postfix expression evaluator, predicts each
// result from the accepted characters on its own Q16.16 value stack, and
// compares every output transaction field by field with the oldest
// prediction. Reports the first ten mismatches and counts all of them.
// ----------------------------------------------------------------------------
module pee_checker import pee_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [7:0]        i_symbol,
    input  logic              i_last,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [DATA_W-1:0] i_value,
    input  logic [1:0]        i_status,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        t_status           status;
    } t_outcome;

    logic signed [DATA_W-1:0] operand_stack [STACK_DEPTH];
    int                       stack_level;
    t_status                  held_error;
    t_outcome                 outcome_q [$];

    function automatic logic signed [DATA_W-1:0] clamp_q(input longint v);
        if (v > longint'($signed(Q_MAX))) begin
            return $signed(Q_MAX);
        end
        if (v < longint'($signed(Q_MIN))) begin
            return $signed(Q_MIN);
        end
        return v[DATA_W-1:0];
    endfunction

    task automatic note_error(input t_status code);
        if (held_error == ST_OK) begin
            held_error = code;
        end
    endtask

    task automatic push_operand(input logic signed [DATA_W-1:0] v);
        if (stack_level < STACK_DEPTH) begin
            operand_stack[stack_level] = v;
            stack_level++;
        end else begin
            note_error(ST_OVER);
        end
    endtask

    task automatic apply_operator(input logic [7:0] sym);
        logic signed [DATA_W-1:0] rhs;
        logic signed [DATA_W-1:0] lhs;
        logic signed [DATA_W-1:0] res;
        longint                   prod;
        if (stack_level < 2) begin
            note_error(ST_UNDER);
            return;
        end
        rhs = operand_stack[stack_level-1];
        lhs = operand_stack[stack_level-2];
        stack_level -= 2;
        case (sym)
            CH_PLUS: begin
                res = clamp_q(longint'(lhs) + longint'(rhs));
            end
            CH_MINUS: begin
                res = clamp_q(longint'(lhs) - longint'(rhs));
            end
            CH_STAR: begin
                prod = longint'(lhs) * longint'(rhs);
                res  = clamp_q(prod >>> 16);
            end
            default: begin
                if (rhs == 0) begin
                    note_error(ST_DIVZ);
                    res = '0;
                end else begin
                    res = clamp_q((longint'(lhs) * 65536) / longint'(rhs));
                end
            end
        endcase
        push_operand(res);
    endtask

    task automatic evaluate_symbol(input logic [7:0] sym, input logic last);
        t_outcome outcome;
        if (sym >= CH_ZERO && sym <= CH_NINE) begin
            push_operand(DATA_W'(sym - CH_ZERO) << 16);
        end else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR
                     || sym == CH_SLASH) begin
            apply_operator(sym);
        end
        if (last) begin
            if (stack_level > 0) begin
                outcome.value = operand_stack[stack_level-1];
            end else begin
                outcome.value = '0;
                note_error(ST_UNDER);
            end
            outcome.status = held_error;
            outcome_q.push_back(outcome);
            stack_level = 0;
            held_error  = ST_OK;
        end
    endtask

    task automatic record_failure(input string what, input t_outcome want);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t: %s: expected value %h status %0d, got value %h status %0d",
                     $realtime, what, want.value, want.status, i_value, i_status);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            stack_level = 0;
            held_error  = ST_OK;
            outcome_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (outcome_q.size() == 0) begin
                    want = '0;
                    record_failure("result with none pending", want);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_value !== want.value || i_status !== want.status) begin
                        record_failure("result mismatch", want);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                evaluate_symbol(i_symbol, i_last);
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the postfix expression evaluator with directed expressions and then
// random well-formed, deep, broken and single-character expressions, with
// random idling on both channels. The checker beside the block predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top import pee_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 425;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [7:0]        i_symbol;
    logic              i_last;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [DATA_W-1:0] o_value;
    logic [1:0]        o_status;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   item_count  = 0;
    logic no_idle     = 1'b0;
    logic [7:0] formula_q [$];

    postfix_expression_evaluator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_symbol    (i_symbol),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_status    (o_status)
    );

    pee_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_symbol     (i_symbol),
        .i_last       (i_last),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_value      (o_value),
        .i_status     (o_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("postfix_expression_evaluator test failed");
            $finish;
        end
    end

    function automatic logic [7:0] pick_digit();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom_range(0, 1) ? CH_NINE : CH_ZERO;
        end
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] pick_noise();
        logic [7:0] sym;
        do begin
            sym = 8'($urandom_range(0, 255));
        end while ((sym >= CH_ZERO && sym <= CH_NINE) || sym == CH_PLUS
                   || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH);
        return sym;
    endfunction

    task automatic send_symbol(input logic [7:0] sym, input logic last);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_symbol   <= sym;
        i_last     <= last;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
        if ((sym >= CH_ZERO && sym <= CH_NINE) || sym == CH_PLUS || sym == CH_MINUS
            || sym == CH_STAR || sym == CH_SLASH) begin
            item_count++;
        end
    endtask

    task automatic send_formula();
        for (int k = 0; k < formula_q.size(); k++) begin
            send_symbol(formula_q[k], k == formula_q.size() - 1);
        end
    endtask

    task automatic send_text(input string text);
        formula_q.delete();
        for (int k = 0; k < text.len(); k++) begin
            formula_q.push_back(text[k]);
        end
        send_formula();
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic build_wellformed(input int n_ops, input int noise_pct);
        int level;
        int digits_left;
        int ops_left;
        formula_q.delete();
        level       = 0;
        digits_left = n_ops + 1;
        ops_left    = n_ops;
        while (digits_left + ops_left > 0) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                formula_q.push_back(pick_noise());
            end
            if (ops_left > 0 && level >= 2 && (digits_left == 0
                || level >= STACK_DEPTH || $urandom_range(0, 1) == 1)) begin
                formula_q.push_back(pick_operator());
                ops_left--;
                level--;
            end else begin
                formula_q.push_back(pick_digit());
                digits_left--;
                level++;
            end
        end
    endtask

    task automatic build_random_formula();
        int  n_push;
        int  n_ops;
        int  kind;
        kind = $urandom_range(0, 19);
        formula_q.delete();
        if (kind < 14) begin
            build_wellformed($urandom_range(0, 12), $urandom_range(0, 1) ? 5 : 0);
        end else if (kind < 16) begin
            n_push = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
            n_ops  = $urandom_range(0, STACK_DEPTH + 4);
            repeat (n_push) formula_q.push_back(pick_digit());
            repeat (n_ops) formula_q.push_back(pick_operator());
        end else if (kind < 18) begin
            repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 2))
                    0:       formula_q.push_back(pick_digit());
                    1:       formula_q.push_back(pick_operator());
                    default: formula_q.push_back(pick_noise());
                endcase
            end
        end else begin
            formula_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int stall;
        i_out_ready = 1'b0;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(negedge i_clk);
            while (!o_out_valid) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_symbol   = '0;
        i_last     = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_text("9");
        send_text("09-5+");
        send_text("72/");
        send_text("30/");
        send_text("+");
        send_symbol(8'hFF, 1'b1);
        send_text("99*9*9*9*");
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            no_idle = (phase == 1);
            while (item_count < (phase + 1) * PHASE_ITEMS) begin
                build_random_formula();
                send_formula();
            end
            drain_results();
        end

        repeat (60) @(posedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("postfix_expression_evaluator test passed");
        end else begin
            $display("postfix_expression_evaluator test failed");
        end
        $finish;
    end

endmodule
